>>> rtl/rblc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rblc_pkg
// Shared types and constants of the ROM bank cache lookup unit.
// ----------------------------------------------------------------------------
package rblc_pkg;

  localparam int ROM_LEN_W = 24;
  localparam int STATUS_W  = 3;
  localparam int AGE_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Half of the age range; a difference above it means "older".
  localparam logic [AGE_W-1:0] AGE_HALF = 8'd127;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DIRECT       = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_HIT          = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISS         = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_RESTART      = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_MODE = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MISS
  } ctrl_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;         // latch a new transaction
    logic restart;      // clear cache, preload bank 0, report
    logic emit_oor;     // report out of range
    logic emit_direct;  // report direct access
    logic scan_step;    // fold current slot into victim search, advance
    logic hit_commit;   // stamp current slot, report hit
    logic miss_commit;  // retag victim, report miss
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_restart;
    logic out_of_range;
    logic direct;
    logic hit;
    logic last;
  } dp_status_t;

endpackage

>>> rtl/rblc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rblc_ctrl
// Sequencer: decode, slot scan and commit of one transaction at a time.
// ----------------------------------------------------------------------------
module rblc_ctrl import rblc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.is_restart) begin
          cmd_o.restart = 1'b1;
          state_d       = ST_IDLE;
        end else if (status_i.out_of_range) begin
          cmd_o.emit_oor = 1'b1;
          state_d        = ST_IDLE;
        end else if (status_i.direct) begin
          cmd_o.emit_direct = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          cmd_o.hit_commit = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (status_i.last) begin
            state_d = ST_MISS;
          end
        end
      end
      ST_MISS: begin
        cmd_o.miss_commit = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> rtl/rblc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rblc_dp
// Datapath: config registers, slot tags/ages, victim search, result register.
// ----------------------------------------------------------------------------
module rblc_dp import rblc_pkg::*; #(
  parameter int SLOTS        = 8,
  parameter int BANK_BYTES   = 16384,
  parameter int ADDRESS_BITS = 23,
  localparam int OFF_W  = $clog2(BANK_BYTES),
  localparam int BANK_W = ADDRESS_BITS - OFF_W,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int FILL_W = OFF_W + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config
  input  logic                    cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ROM_LEN_W-1:0]    cfg_data_i,
  // transaction in
  input  logic                    action_i,
  input  logic [ADDRESS_BITS-1:0] byte_address_i,
  // control
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  // result
  output logic                    done_o,
  output logic [STATUS_W-1:0]     status_code_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic [BANK_W-1:0]       bank_o,
  output logic [OFF_W-1:0]        offset_o,
  output logic [FILL_W-1:0]       fill_length_o
);

  localparam int CMP_W = (ADDRESS_BITS > ROM_LEN_W) ? ADDRESS_BITS : ROM_LEN_W;
  localparam logic [FILL_W-1:0] BANK_FILL = FILL_W'(BANK_BYTES);

  // config
  logic [ROM_LEN_W-1:0] rom_len_q;
  logic                 direct_q;

  // latched transaction
  logic                    action_q;
  logic [ADDRESS_BITS-1:0] addr_q;

  // cache state
  logic [BANK_W-1:0] tag_q [SLOTS];
  logic [SLOTS-1:0]  valid_q;
  logic [AGE_W-1:0]  age_q [SLOTS];
  logic [AGE_W-1:0]  age_ctr_q;

  // scan state
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] victim_q;
  logic [AGE_W-1:0]  oldest_q;
  logic              found_empty_q;

  // result
  logic                done_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [BANK_W-1:0]   res_bank_q;
  logic [OFF_W-1:0]    res_off_q;
  logic [FILL_W-1:0]   res_fill_q;

  logic [BANK_W-1:0] bank;
  logic [OFF_W-1:0]  offset;
  logic [CMP_W-1:0]  addr_ext, rom_len_ext, base_ext, remain;
  logic [FILL_W-1:0] miss_fill, restart_fill;
  logic [AGE_W-1:0]  age_inc, age_diff;
  logic              slot_hit;

  assign bank        = addr_q[ADDRESS_BITS-1:OFF_W];
  assign offset      = addr_q[OFF_W-1:0];
  assign addr_ext    = CMP_W'(addr_q);
  assign rom_len_ext = CMP_W'(rom_len_q);
  assign base_ext    = CMP_W'({bank, {OFF_W{1'b0}}});
  assign remain      = rom_len_ext - base_ext;

  // bank base is below rom length whenever a miss is reported
  assign miss_fill    = (remain >= CMP_W'(BANK_BYTES)) ? BANK_FILL : remain[FILL_W-1:0];
  assign restart_fill = (rom_len_q >= ROM_LEN_W'(BANK_BYTES)) ? BANK_FILL
                                                               : rom_len_q[FILL_W-1:0];

  assign age_inc  = age_ctr_q + 1'b1;
  assign age_diff = age_q[idx_q] - oldest_q;
  assign slot_hit = valid_q[idx_q] && (tag_q[idx_q] == bank);

  assign status_o.is_restart   = action_q;
  assign status_o.out_of_range = (addr_ext >= rom_len_ext);
  assign status_o.direct       = direct_q;
  assign status_o.hit          = slot_hit;
  assign status_o.last         = (idx_q == SLOT_W'(SLOTS - 1));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_len_q <= '0;
      direct_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROM_LENGTH:  rom_len_q <= cfg_data_i;
        CFG_DIRECT_MODE: direct_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // transaction latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      addr_q   <= byte_address_i;
    end
  end

  // cache state and victim search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_q[i] <= '0;
        age_q[i] <= '0;
      end
      valid_q       <= SLOTS'(1);
      age_ctr_q     <= '0;
      idx_q         <= '0;
      victim_q      <= '0;
      oldest_q      <= '0;
      found_empty_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q         <= '0;
        victim_q      <= '0;
        found_empty_q <= 1'b0;
      end
      if (cmd_i.restart) begin
        for (int i = 0; i < SLOTS; i++) begin
          tag_q[i] <= '0;
          age_q[i] <= '0;
        end
        valid_q   <= SLOTS'(1);
        age_ctr_q <= '0;
      end
      if (cmd_i.scan_step) begin
        if (idx_q == '0) begin
          oldest_q <= age_q[0];
        end else if (!found_empty_q) begin
          if (!valid_q[idx_q]) begin
            victim_q      <= idx_q;
            found_empty_q <= 1'b1;
          end else if (age_diff > AGE_HALF) begin
            victim_q <= idx_q;
            oldest_q <= age_q[idx_q];
          end
        end
        if (!status_o.last) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_i.hit_commit) begin
        age_ctr_q    <= age_inc;
        age_q[idx_q] <= age_inc;
      end
      if (cmd_i.miss_commit) begin
        valid_q[victim_q] <= 1'b1;
        tag_q[victim_q]   <= bank;
        age_q[victim_q]   <= age_inc;
        age_ctr_q         <= age_inc;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.restart | cmd_i.emit_oor | cmd_i.emit_direct |
                cmd_i.hit_commit | cmd_i.miss_commit;
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.restart) begin
      res_status_q <= STATUS_RESTART;
      res_slot_q   <= '0;
      res_bank_q   <= '0;
      res_off_q    <= '0;
      res_fill_q   <= restart_fill;
    end else if (cmd_i.emit_oor) begin
      res_status_q <= STATUS_OUT_OF_RANGE;
      res_slot_q   <= '0;
      res_bank_q   <= '0;
      res_off_q    <= '0;
      res_fill_q   <= '0;
    end else if (cmd_i.emit_direct) begin
      res_status_q <= STATUS_DIRECT;
      res_slot_q   <= '0;
      res_bank_q   <= bank;
      res_off_q    <= offset;
      res_fill_q   <= '0;
    end else if (cmd_i.hit_commit) begin
      res_status_q <= STATUS_HIT;
      res_slot_q   <= idx_q;
      res_bank_q   <= bank;
      res_off_q    <= offset;
      res_fill_q   <= '0;
    end else if (cmd_i.miss_commit) begin
      res_status_q <= STATUS_MISS;
      res_slot_q   <= victim_q;
      res_bank_q   <= bank;
      res_off_q    <= offset;
      res_fill_q   <= miss_fill;
    end
  end

  assign done_o        = done_q;
  assign status_code_o = res_status_q;
  assign slot_o        = res_slot_q;
  assign bank_o        = res_bank_q;
  assign offset_o      = res_off_q;
  assign fill_length_o = res_fill_q;

endmodule

>>> rtl/rom_bank_cache_lru_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_bank_cache_lru_lookup
// Tag and replacement unit of a fully associative ROM bank cache.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                   Transaction taken when
// -------   ---------------------------------------   ----------------------------
// request   start_i, action_i, byte_address_i          start_i && !busy_o
// result    done_o, status_o, slot_o, bank_o,          done_o (one cycle, no stall)
//           offset_o, fill_length_o
// config    cfg_valid_i, cfg_index_i, cfg_data_i,      cfg_valid_i && cfg_ready_o
//           cfg_ready_o (high while idle)
//
// Flow: restart, out-of-range and direct transactions are decided in the
// decode state and reported from there; a cached access then scans slots
// from slot 0 until a hit, or through all SLOTS slots and then commits the
// victim on a miss. The slot scan reads one tag and age per cycle.
// busy_o drops in the cycle the result is shown, so a new transaction can be
// taken while the receiver samples the result.
// Reset (rst_ni low, async): config cleared, slot 0 holds bank 0, others
// empty, all ages and the age counter zero. No clearing pass needed.
// The receiver cannot stall; config writes are taken only while idle.
// ----------------------------------------------------------------------------
module rom_bank_cache_lru_lookup import rblc_pkg::*; #(
  parameter int SLOTS        = 8,
  parameter int BANK_BYTES   = 16384,
  parameter int ADDRESS_BITS = 23
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // request
  input  logic                                       start_i,
  output logic                                       busy_o,
  input  logic                                       action_i,
  input  logic [ADDRESS_BITS-1:0]                    byte_address_i,
  // result
  output logic                                       done_o,
  output logic [STATUS_W-1:0]                        status_o,
  output logic [$clog2(SLOTS)-1:0]                   slot_o,
  output logic [ADDRESS_BITS-$clog2(BANK_BYTES)-1:0] bank_o,
  output logic [$clog2(BANK_BYTES)-1:0]              offset_o,
  output logic [$clog2(BANK_BYTES):0]                fill_length_o,
  // config
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                       cfg_index_i,
  input  logic [ROM_LEN_W-1:0]                       cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  // Registers take a write only while no transaction is in flight.
  assign cfg_ready_o = !busy_o;

  rblc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  rblc_dp #(
    .SLOTS        (SLOTS),
    .BANK_BYTES   (BANK_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .byte_address_i (byte_address_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .done_o         (done_o),
    .status_code_o  (status_o),
    .slot_o         (slot_o),
    .bank_o         (bank_o),
    .offset_o       (offset_o),
    .fill_length_o  (fill_length_o)
  );

  // Only one commit action per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.restart, cmd.emit_oor, cmd.emit_direct,
              cmd.hit_commit, cmd.miss_commit}))
    else $error("multiple commit actions in one cycle");

  // A result only ends a transaction that was in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without a transaction in flight");

  // An accepted transaction makes the unit busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not start");

  // A miss always loads at least one byte; a hit loads none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_MISS) |-> (fill_length_o != '0))
    else $error("miss reported with empty fill");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_HIT) |-> (fill_length_o == '0))
    else $error("hit reported with nonzero fill");

endmodule

>>> tb/sv/rom_bank_cache_lru_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_bank_cache_lru_lookup_tb
// Self-checking bench for the ROM bank cache tag and replacement unit.
// It runs a short directed table of stimulus, then random phases that re-program
// the ROM length and direct mode between them. Every accepted request goes
// through a bench-side lookup model of tags, ages and the victim search, and
// every result strobe is compared field by field against the oldest entry of
// the expected-result queue.
// ----------------------------------------------------------------------------
module rom_bank_cache_lru_lookup_tb import rblc_pkg::*;;

  localparam int SLOTS        = 8;
  localparam int BANK_BYTES   = 16384;
  localparam int ADDRESS_BITS = 23;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int OFF_W        = $clog2(BANK_BYTES);
  localparam int BANK_W       = ADDRESS_BITS - OFF_W;
  localparam int FILL_W       = OFF_W + 1;

  localparam int ROM_MAX      = 8388608;   // largest legal ROM length
  localparam int DIR_ROWS     = 30;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 125;
  localparam int DRAIN_CYCLES = SLOTS + 8; // a bit beyond the longest miss
  localparam int TIMEOUT_NS   = 500_000;   // roughly 4x the slowest legal run

  // Request action codes
  localparam logic ACT_ACCESS  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [BANK_W-1:0]   bank;
    logic [OFF_W-1:0]    offset;
    logic [FILL_W-1:0]   fill;
  } lookup_res_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // One line of the directed table: either a request or a register write.
  // Requests with typed set carry a hand-written expectation.
  typedef struct packed {
    row_kind_e               kind;
    logic                    act;
    logic [ADDRESS_BITS-1:0] addr;
    logic [CFG_IDX_W-1:0]    idx;
    logic [ROM_LEN_W-1:0]    data;
    logic                    typed;
    lookup_res_t             res;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    action_i;
  logic [ADDRESS_BITS-1:0] byte_address_i;
  logic                    done_o;
  logic [STATUS_W-1:0]     status_o;
  logic [SLOT_W-1:0]       slot_o;
  logic [BANK_W-1:0]       bank_o;
  logic [OFF_W-1:0]        offset_o;
  logic [FILL_W-1:0]       fill_length_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [ROM_LEN_W-1:0]    cfg_data_i;

  rom_bank_cache_lru_lookup #(
    .SLOTS        (SLOTS),
    .BANK_BYTES   (BANK_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .byte_address_i (byte_address_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .bank_o         (bank_o),
    .offset_o       (offset_o),
    .fill_length_o  (fill_length_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Lookup model: its own copy of tags, ages, age counter and registers
  // --------------------------------------------------------------------------
  logic                 pred_valid [SLOTS];
  logic [BANK_W-1:0]    pred_bank  [SLOTS];
  logic [AGE_W-1:0]     pred_age   [SLOTS];
  logic [AGE_W-1:0]     pred_age_ctr;
  logic [ROM_LEN_W-1:0] pred_rom_len;
  logic                 pred_direct;

  lookup_res_t exp_results [$];
  int          err_count;

  // Empty every slot, zero the ages, then preload bank 0 into slot 0.
  function automatic void clear_cache_model();
    for (int i = 0; i < SLOTS; i++) begin
      pred_valid[i] = 1'b0;
      pred_bank[i]  = '0;
      pred_age[i]   = '0;
    end
    pred_age_ctr  = '0;
    pred_valid[0] = 1'b1;
  endfunction

  // Expected result of one request; advances the model state as the block does.
  function automatic lookup_res_t lookup_predict(input logic act,
                                                 input logic [ADDRESS_BITS-1:0] addr);
    lookup_res_t       r;
    logic [SLOT_W-1:0] victim;
    logic [AGE_W-1:0]  oldest;
    logic [AGE_W-1:0]  diff;
    logic              found_empty;
    int unsigned       base;
    r = '0;
    if (act == ACT_RESTART) begin
      clear_cache_model();
      r.status = STATUS_RESTART;
      r.fill   = (pred_rom_len < BANK_BYTES) ? FILL_W'(pred_rom_len) : FILL_W'(BANK_BYTES);
      return r;
    end
    // Range check comes before direct mode
    if (32'(addr) >= 32'(pred_rom_len)) begin
      r.status = STATUS_OUT_OF_RANGE;
      return r;
    end
    r.bank   = BANK_W'(addr / BANK_BYTES);
    r.offset = OFF_W'(addr % BANK_BYTES);
    if (pred_direct) begin
      r.status = STATUS_DIRECT;
      return r;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (pred_valid[i] && pred_bank[i] == r.bank) begin
        pred_age_ctr = pred_age_ctr + 1'b1;
        pred_age[i]  = pred_age_ctr;
        r.status     = STATUS_HIT;
        r.slot       = SLOT_W'(i);
        return r;
      end
    end
    // Victim: first empty slot from 1 up, else oldest by wrapping age distance
    victim      = '0;
    oldest      = pred_age[0];
    found_empty = 1'b0;
    for (int i = 1; i < SLOTS; i++) begin
      if (!found_empty) begin
        diff = pred_age[i] - oldest;
        if (!pred_valid[i]) begin
          victim      = SLOT_W'(i);
          found_empty = 1'b1;
        end else if (diff > AGE_HALF) begin
          oldest = pred_age[i];
          victim = SLOT_W'(i);
        end
      end
    end
    pred_valid[victim] = 1'b1;
    pred_bank[victim]  = r.bank;
    pred_age_ctr       = pred_age_ctr + 1'b1;
    pred_age[victim]   = pred_age_ctr;
    // Last bank of the ROM may be short
    base = 32'(r.bank) * BANK_BYTES;
    if (base + BANK_BYTES > 32'(pred_rom_len))
      r.fill = FILL_W'(32'(pred_rom_len) - base);
    else
      r.fill = FILL_W'(BANK_BYTES);
    r.status = STATUS_MISS;
    r.slot   = victim;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  function automatic dir_row_t item_row(input logic act, input int addr);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.act  = act;
    row.addr = ADDRESS_BITS'(addr);
    return row;
  endfunction

  function automatic dir_row_t checked_row(input logic act, input int addr,
                                           input logic [STATUS_W-1:0] st, input int sl,
                                           input int bk, input int off, input int fl);
    dir_row_t row;
    row       = item_row(act, addr);
    row.typed = 1'b1;
    row.res   = '{st, SLOT_W'(sl), BANK_W'(bk), OFF_W'(off), FILL_W'(fl)};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = ROM_LEN_W'(data);
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers (inputs move on the falling edge)
  // --------------------------------------------------------------------------
  logic no_idle;   // set for burst phases: back-to-back requests

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Present one request, hold it until accepted, then queue its expectation.
  // start_i stays high into the next call when there is no gap, so it is
  // never lowered and raised in the same step.
  task automatic send_request(input logic act, input logic [ADDRESS_BITS-1:0] addr,
                              input logic typed, input lookup_res_t typed_res);
    int          gap;
    lookup_res_t pred;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i        <= 1'b1;
    action_i       <= act;
    byte_address_i <= addr;
    do @(posedge clk_i); while (busy_o);
    // Model always advances; typed rows replace only the compared value
    pred = lookup_predict(act, addr);
    exp_results.push_back(typed ? typed_res : pred);
  endtask

  // Drop start and let every outstanding result come back.
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [ROM_LEN_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ROM_LENGTH)
      pred_rom_len = data;
    else if (idx == CFG_DIRECT_MODE)
      pred_direct = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checker (outputs sampled on the rising edge)
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lookup_res_t got;
    lookup_res_t want;
    if (rst_ni && done_o) begin
      got = '{status_o, slot_o, bank_o, offset_o, fill_length_o};
      if (exp_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: result with nothing expected: status=%0d slot=%0d bank=%0d %s%0d %s%0d",
                   $realtime, got.status, got.slot, got.bank, "off=", got.offset,
                   "fill=", got.fill);
      end else begin
        want = exp_results.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: mismatch exp status=%0d slot=%0d bank=%0d off=%0d fill=%0d",
                     $realtime, want.status, want.slot, want.bank, want.offset, want.fill);
            $display("           got status=%0d slot=%0d bank=%0d off=%0d fill=%0d",
                     got.status, got.slot, got.bank, got.offset, got.fill);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("rom_bank_cache_lru_lookup_tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  dir_row_t dir_tab [DIR_ROWS];

  initial begin
    logic [BANK_W-1:0]       pool [16];
    int                      pool_n;
    int                      max_bank;
    int                      restart_pct;
    int                      r;
    int unsigned             base;
    int unsigned             rom_len;
    logic                    act;
    logic [ADDRESS_BITS-1:0] addr;

    // Every input known from time 0; reset held low at the start
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    action_i       = ACT_ACCESS;
    byte_address_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_ROM_LENGTH;
    cfg_data_i     = '0;
    err_count      = 0;
    no_idle        = 1'b0;
    pred_rom_len   = '0;
    pred_direct    = 1'b0;
    clear_cache_model();

    dir_tab = '{
      // After reset ROM length is 0: everything is out of range
      checked_row(ACT_ACCESS,  0,          STATUS_OUT_OF_RANGE, 0, 0, 0, 0),
      checked_row(ACT_ACCESS,  'h7FFFFF,   STATUS_OUT_OF_RANGE, 0, 0, 0, 0),
      // Restart with nothing to load
      checked_row(ACT_RESTART, 'h7FFFFF,   STATUS_RESTART, 0, 0, 0, 0),
      cfg_row(CFG_ROM_LENGTH, ROM_MAX),
      checked_row(ACT_RESTART, 0,          STATUS_RESTART, 0, 0, 0, BANK_BYTES),
      // Preloaded bank 0 hits in slot 0; top byte misses into first empty slot
      checked_row(ACT_ACCESS,  0,          STATUS_HIT, 0, 0, 0, 0),
      checked_row(ACT_ACCESS,  'h7FFFFF,   STATUS_MISS, 1, 511, BANK_BYTES - 1, BANK_BYTES),
      // Fill the remaining empty slots
      item_row(ACT_ACCESS, 'h04000),
      item_row(ACT_ACCESS, 'h08001),
      item_row(ACT_ACCESS, 'h0C002),
      item_row(ACT_ACCESS, 'h10003),
      item_row(ACT_ACCESS, 'h14004),
      item_row(ACT_ACCESS, 'h18005),
      // Refresh slot 0, then evict the least recently used slot
      item_row(ACT_ACCESS, 'h00003),
      item_row(ACT_ACCESS, 'h1C3FF),
      item_row(ACT_ACCESS, 'h7FFFFF),
      // Short last bank: three full banks plus 100 bytes
      cfg_row(CFG_ROM_LENGTH, 3 * BANK_BYTES + 100),
      checked_row(ACT_RESTART, 0,          STATUS_RESTART, 0, 0, 0, BANK_BYTES),
      item_row(ACT_ACCESS, 3 * BANK_BYTES + 99),
      checked_row(ACT_ACCESS,  3 * BANK_BYTES + 100, STATUS_OUT_OF_RANGE, 0, 0, 0, 0),
      // Direct mode bypasses the cache; range check still wins
      cfg_row(CFG_DIRECT_MODE, 1),
      checked_row(ACT_ACCESS,  12345,      STATUS_DIRECT, 0, 0, 12345, 0),
      checked_row(ACT_ACCESS,  3 * BANK_BYTES + 99, STATUS_DIRECT, 0, 3, 99, 0),
      checked_row(ACT_ACCESS,  3 * BANK_BYTES + 100, STATUS_OUT_OF_RANGE, 0, 0, 0, 0),
      checked_row(ACT_RESTART, 0,          STATUS_RESTART, 0, 0, 0, BANK_BYTES),
      // One-byte ROM
      cfg_row(CFG_DIRECT_MODE, 0),
      cfg_row(CFG_ROM_LENGTH, 1),
      checked_row(ACT_RESTART, 0,          STATUS_RESTART, 0, 0, 0, 1),
      checked_row(ACT_ACCESS,  0,          STATUS_HIT, 0, 0, 0, 0),
      checked_row(ACT_ACCESS,  1,          STATUS_OUT_OF_RANGE, 0, 0, 0, 0)
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_request(dir_tab[i].act, dir_tab[i].addr, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Random phases. The first three keep the cache on and no restarts, so
    // the age counter runs past its wrap; later ones mix in short ROMs,
    // direct mode and restarts.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      r = $urandom_range(3);
      if (p == 0 || r == 3)
        rom_len = ROM_MAX;
      else if (p < 3 || r == 1)
        rom_len = $urandom_range(ROM_MAX, 1);
      else if (r == 0)
        rom_len = $urandom_range(BANK_BYTES - 1, 1);
      else
        rom_len = $urandom_range(511, 1) * BANK_BYTES + $urandom_range(200);
      if (rom_len > ROM_MAX) rom_len = ROM_MAX;
      cfg_write(CFG_ROM_LENGTH, ROM_LEN_W'(rom_len));
      cfg_write(CFG_DIRECT_MODE, ROM_LEN_W'((p >= 3) && ($urandom_range(3) == 0)));
      restart_pct = (p < 3) ? 0 : 3;
      no_idle     = ($urandom_range(3) == 0);

      // Working set of banks; more than SLOTS of them forces evictions
      max_bank = (rom_len - 1) / BANK_BYTES;
      pool_n   = $urandom_range(14, 4);
      for (int j = 0; j < pool_n; j++)
        pool[j] = BANK_W'($urandom_range(max_bank));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r   = $urandom_range(99);
        act = ACT_ACCESS;
        if (r < restart_pct) begin
          act  = ACT_RESTART;
          addr = ADDRESS_BITS'($urandom);
        end else if (r < restart_pct + 15) begin
          // Noise: anywhere in the address space
          addr = ADDRESS_BITS'($urandom);
        end else begin
          base = 32'(pool[$urandom_range(pool_n - 1)]) * BANK_BYTES;
          addr = ADDRESS_BITS'(base + $urandom_range(BANK_BYTES - 1) % (rom_len - base));
        end
        send_request(act, addr, 1'b0, '0);
      end
    end

    // Drain
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && exp_results.size() == 0) begin
      $display("rom_bank_cache_lru_lookup_tb passed");
    end else begin
      $display("rom_bank_cache_lru_lookup_tb failed");
    end
    $finish;
  end

endmodule
